### src/srt_pkg.sv
// Package with the shared constants, codes and handoff types of the session registry table.
`timescale 1ns / 1ps

package srt_pkg;

    localparam int SLOT_COUNT_DEF   = 16;
    localparam int KEY_BITS_DEF     = 32;
    localparam int HANDLE_BITS_DEF  = 16;

    localparam int OP_BITS          = 2;
    localparam int KEY_PORT_BITS    = 32;
    localparam int GEN_BITS         = 64;
    localparam int HANDLE_PORT_BITS = 16;
    localparam int STATUS_BITS      = 3;

    localparam logic [OP_BITS-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_DROP = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FIND = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND    = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_GEN_MISMATCH = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL         = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NULL         = 3'd4;

    typedef struct packed {
        logic hit;
        logic free;
        logic gen_eq;
    } scan_flags_t;

    typedef struct packed {
        logic refresh;
        logic fill;
        logic drop;
    } commit_t;

endpackage

### src/srt_cell.sv
// One slot of the table: stored entry, scan step toward the next slot and write-back.
`timescale 1ns / 1ps

module srt_cell #(
    parameter int KEY_BITS    = srt_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = srt_pkg::HANDLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_in,
    input  srt_pkg::scan_flags_t          flags_in,
    input  logic [HANDLE_BITS-1:0]        hfound_in,
    input  logic [KEY_BITS-1:0]           key,
    input  logic [srt_pkg::GEN_BITS-1:0]  gen,
    input  logic [HANDLE_BITS-1:0]        handle,
    input  srt_pkg::commit_t              commit,
    output logic                          step_out,
    output srt_pkg::scan_flags_t          flags_out,
    output logic [HANDLE_BITS-1:0]        hfound_out
);
    import srt_pkg::*;

    logic                   valid_reg, valid_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [GEN_BITS-1:0]    gen_reg, gen_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic                   mark_hit_reg, mark_hit_next;
    logic                   mark_free_reg, mark_free_next;
    logic                   step_reg, step_next;
    scan_flags_t            flags_reg, flags_next;
    logic [HANDLE_BITS-1:0] hfound_reg, hfound_next;

    logic hit_here;
    logic first_hit;

    assign hit_here  = valid_reg && (key_reg == key);
    assign first_hit = hit_here && !flags_in.hit;

    always_comb
    begin
        valid_next     = valid_reg;
        key_next       = key_reg;
        gen_next       = gen_reg;
        handle_next    = handle_reg;
        mark_hit_next  = mark_hit_reg;
        mark_free_next = mark_free_reg;
        flags_next     = flags_reg;
        hfound_next    = hfound_reg;
        step_next      = step_in;

        if (step_in)
        begin
            mark_hit_next     = first_hit;
            mark_free_next    = !valid_reg && !flags_in.free;
            flags_next.hit    = flags_in.hit | hit_here;
            flags_next.free   = flags_in.free | !valid_reg;
            flags_next.gen_eq = first_hit ? (gen_reg == gen) : flags_in.gen_eq;
            hfound_next       = first_hit ? handle_reg : hfound_in;
        end

        if (commit.refresh && mark_hit_reg)
        begin
            gen_next    = gen;
            handle_next = handle;
        end

        if (commit.drop && mark_hit_reg)
        begin
            valid_next  = 1'b0;
            handle_next = '0;
        end

        if (commit.fill && mark_free_reg)
        begin
            valid_next  = 1'b1;
            key_next    = key;
            gen_next    = gen;
            handle_next = handle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            mark_hit_reg  <= 1'b0;
            mark_free_reg <= 1'b0;
            step_reg      <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            valid_reg     <= valid_next;
            mark_hit_reg  <= mark_hit_next;
            mark_free_reg <= mark_free_next;
            step_reg      <= step_next;
            flags_reg     <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        gen_reg    <= gen_next;
        handle_reg <= handle_next;
        hfound_reg <= hfound_next;
    end

    assign step_out   = step_reg;
    assign flags_out  = flags_reg;
    assign hfound_out = hfound_reg;

endmodule

### src/session_registry_table_unit.sv
// Top level of the session registry table: request capture, slot chain and result register.
//
// A transaction is accepted at a rising edge where start is high and busy is low;
// opcode, conn_key, gen_value and handle_in are sampled at that edge.
// The request then walks the chain of slot cells, one slot per cycle, from slot 0
// upward, collecting the lowest matching slot and the lowest free slot.
// When it leaves the last slot, the chosen slot is written in the same cycle.
// The result appears on status and handle_out with done high for exactly one cycle,
// registered from the cycle in which the request leaves the last slot.
// Busy drops in the cycle that shows done, so a new transaction may be accepted at the
// edge that ends it; no new transaction is accepted while one is walking the chain.
// The receiver cannot stall: a result is taken in the cycle in which done is high.
// Reset clears every valid mark, so the table starts empty; busy and done are low.
// Keys, generations and handles of slots are only read while their valid mark is set.
`timescale 1ns / 1ps

module session_registry_table_unit #(
    parameter int SLOT_COUNT  = srt_pkg::SLOT_COUNT_DEF,
    parameter int KEY_BITS    = srt_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = srt_pkg::HANDLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [srt_pkg::OP_BITS-1:0]           opcode,
    input  logic [srt_pkg::KEY_PORT_BITS-1:0]     conn_key,
    input  logic [srt_pkg::GEN_BITS-1:0]          gen_value,
    input  logic [srt_pkg::HANDLE_PORT_BITS-1:0]  handle_in,
    output logic                                  done,
    output logic [srt_pkg::STATUS_BITS-1:0]       status,
    output logic [srt_pkg::HANDLE_PORT_BITS-1:0]  handle_out
);
    import srt_pkg::*;

    logic                        accept;
    logic                        busy_reg, busy_next;
    logic                        go_reg;
    logic                        done_reg;
    logic [OP_BITS-1:0]          op_reg;
    logic [KEY_BITS-1:0]         key_reg;
    logic [GEN_BITS-1:0]         gen_reg;
    logic [HANDLE_BITS-1:0]      handle_reg;
    logic [STATUS_BITS-1:0]      status_reg, status_next;
    logic [HANDLE_PORT_BITS-1:0] handle_out_reg, handle_out_next;

    logic [KEY_BITS-1:0]         key_ext;
    logic [HANDLE_BITS-1:0]      handle_ext;
    logic [HANDLE_BITS-1:0]      hout_full;
    logic [HANDLE_PORT_BITS-1:0] hout_port;

    logic [SLOT_COUNT:0]         step_chain;
    scan_flags_t                 flags_chain [0:SLOT_COUNT];
    logic [HANDLE_BITS-1:0]      hfound_chain [0:SLOT_COUNT];

    logic                        last;
    scan_flags_t                 last_flags;
    commit_t                     commit;

    assign accept = start && !busy_reg;

    generate
        if (KEY_BITS > KEY_PORT_BITS)
        begin : g_key_wide
            assign key_ext = {{(KEY_BITS - KEY_PORT_BITS){1'b0}}, conn_key};
        end
        else if (KEY_BITS == KEY_PORT_BITS)
        begin : g_key_same
            assign key_ext = conn_key;
        end
        else
        begin : g_key_narrow
            assign key_ext = conn_key[KEY_BITS-1:0];
        end

        if (HANDLE_BITS > HANDLE_PORT_BITS)
        begin : g_hdl_wide
            assign handle_ext = {{(HANDLE_BITS - HANDLE_PORT_BITS){1'b0}}, handle_in};
            assign hout_port  = hout_full[HANDLE_PORT_BITS-1:0];
        end
        else if (HANDLE_BITS == HANDLE_PORT_BITS)
        begin : g_hdl_same
            assign handle_ext = handle_in;
            assign hout_port  = hout_full;
        end
        else
        begin : g_hdl_narrow
            assign handle_ext = handle_in[HANDLE_BITS-1:0];
            assign hout_port  = {{(HANDLE_PORT_BITS - HANDLE_BITS){1'b0}}, hout_full};
        end
    endgenerate

    assign step_chain[0]   = go_reg;
    assign flags_chain[0]  = '0;
    assign hfound_chain[0] = '0;

    generate
        for (genvar i = 0; i < SLOT_COUNT; i++)
        begin : g_slot
            srt_cell #(
                .KEY_BITS    (KEY_BITS),
                .HANDLE_BITS (HANDLE_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .step_in    (step_chain[i]),
                .flags_in   (flags_chain[i]),
                .hfound_in  (hfound_chain[i]),
                .key        (key_reg),
                .gen        (gen_reg),
                .handle     (handle_reg),
                .commit     (commit),
                .step_out   (step_chain[i+1]),
                .flags_out  (flags_chain[i+1]),
                .hfound_out (hfound_chain[i+1])
            );
        end
    endgenerate

    assign last       = step_chain[SLOT_COUNT];
    assign last_flags = flags_chain[SLOT_COUNT];

    always_comb
    begin
        commit      = '0;
        status_next = ST_OK;
        hout_full   = '0;
        if (last)
        begin
            case (op_reg)
                OP_ADD:
                begin
                    if (handle_reg == '0)
                        status_next = ST_NULL;
                    else if (last_flags.hit)
                        commit.refresh = 1'b1;
                    else if (last_flags.free)
                        commit.fill = 1'b1;
                    else
                        status_next = ST_FULL;
                end
                OP_DROP:
                begin
                    if (!last_flags.hit)
                        status_next = ST_NOT_FOUND;
                    else
                        commit.drop = 1'b1;
                end
                OP_FIND:
                begin
                    if (!last_flags.hit)
                        status_next = ST_NOT_FOUND;
                    else if (!last_flags.gen_eq)
                        status_next = ST_GEN_MISMATCH;
                    else
                        hout_full = hfound_chain[SLOT_COUNT];
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    assign handle_out_next = hout_port;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (last)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            go_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            go_reg   <= accept;
            done_reg <= last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= opcode;
            key_reg    <= key_ext;
            gen_reg    <= gen_value;
            handle_reg <= handle_ext;
        end
        if (last)
        begin
            status_reg     <= status_next;
            handle_out_reg <= handle_out_next;
        end
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign status     = status_reg;
    assign handle_out = handle_out_reg;

    a_single_token : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(step_chain))
        else $error("More than one transaction is walking the slot chain.");

    a_idle_chain : assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (step_chain == '0))
        else $error("Slot chain is active while the unit is not busy.");

    a_done_follows_last : assert property (@(posedge clk) disable iff (!rst_n)
        last |=> (done_reg && !busy_reg))
        else $error("Result strobe or busy release missing after the last slot.");

    a_done_from_busy : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("Result strobe without a transaction in flight.");

    a_status_range : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (status_reg <= ST_NULL))
        else $error("Result status carries an undefined code.");

endmodule

### verif/tb_session_registry_table_unit.sv
// Self-checking testbench for the session registry table unit: directed and random transactions.
`timescale 1ns / 1ps

module tb_session_registry_table_unit;

    import srt_pkg::*;

    localparam logic [OP_BITS-1:0] OP_NONE = 2'd3;
    localparam int SLOTS    = SLOT_COUNT_DEF;
    localparam int KEY_POOL = 24;
    localparam logic [GEN_BITS-1:0] GEN_ALL_ONES = {GEN_BITS{1'b1}};

    typedef struct packed {
        logic [STATUS_BITS-1:0]      status;
        logic [HANDLE_PORT_BITS-1:0] handle;
    } session_reply_t;

    class session_scoreboard;
        bit                          slot_used[SLOTS];
        logic [KEY_PORT_BITS-1:0]    slot_key[SLOTS];
        logic [GEN_BITS-1:0]         slot_gen[SLOTS];
        logic [HANDLE_PORT_BITS-1:0] slot_handle[SLOTS];
        session_reply_t              pending_replies[$];
        int                          error_count;

        function new();
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            error_count = 0;
        endfunction

        function int find_slot(logic [KEY_PORT_BITS-1:0] key);
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && slot_key[i] == key)
                    return i;
            return -1;
        endfunction

        function bit stored_gen(logic [KEY_PORT_BITS-1:0] key, output logic [GEN_BITS-1:0] gen);
            int hit;
            hit = find_slot(key);
            gen = '0;
            if (hit < 0)
                return 1'b0;
            gen = slot_gen[hit];
            return 1'b1;
        endfunction

        function void note_request(logic [OP_BITS-1:0] op, logic [KEY_PORT_BITS-1:0] key,
                                   logic [GEN_BITS-1:0] gen,
                                   logic [HANDLE_PORT_BITS-1:0] handle);
            int             hit;
            int             free_idx;
            session_reply_t reply;
            hit = find_slot(key);
            free_idx = -1;
            reply.status = ST_OK;
            reply.handle = '0;
            case (op)
                OP_ADD:
                begin
                    if (handle == '0)
                        reply.status = ST_NULL;
                    else if (hit >= 0)
                    begin
                        slot_gen[hit] = gen;
                        slot_handle[hit] = handle;
                    end
                    else
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (!slot_used[i])
                            begin
                                free_idx = i;
                                break;
                            end
                        end
                        if (free_idx < 0)
                            reply.status = ST_FULL;
                        else
                        begin
                            slot_used[free_idx] = 1'b1;
                            slot_key[free_idx] = key;
                            slot_gen[free_idx] = gen;
                            slot_handle[free_idx] = handle;
                        end
                    end
                end
                OP_DROP:
                begin
                    if (hit < 0)
                        reply.status = ST_NOT_FOUND;
                    else
                    begin
                        slot_used[hit] = 1'b0;
                        slot_handle[hit] = '0;
                    end
                end
                OP_FIND:
                begin
                    if (hit < 0)
                        reply.status = ST_NOT_FOUND;
                    else if (slot_gen[hit] != gen)
                        reply.status = ST_GEN_MISMATCH;
                    else
                        reply.handle = slot_handle[hit];
                end
                default:
                    ;
            endcase
            pending_replies.push_back(reply);
        endfunction

        function void check_result(logic [STATUS_BITS-1:0] status,
                                   logic [HANDLE_PORT_BITS-1:0] handle);
            session_reply_t want;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual status %0d handle_out %h",
                         $time, status, handle);
                error_count++;
                return;
            end
            want = pending_replies.pop_front();
            if (status !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, status);
                error_count++;
            end
            if (handle !== want.handle)
            begin
                $display("%0t: handle_out mismatch: expected %h, actual %h",
                         $time, want.handle, handle);
                error_count++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [OP_BITS-1:0]          opcode;
    logic [KEY_PORT_BITS-1:0]    conn_key;
    logic [GEN_BITS-1:0]         gen_value;
    logic [HANDLE_PORT_BITS-1:0] handle_in;
    logic                        done;
    logic [STATUS_BITS-1:0]      status;
    logic [HANDLE_PORT_BITS-1:0] handle_out;

    session_scoreboard        board = new();
    int                       idle_pct;
    logic [KEY_PORT_BITS-1:0] key_pool[KEY_POOL];

    session_registry_table_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .conn_key   (conn_key),
        .gen_value  (gen_value),
        .handle_in  (handle_in),
        .done       (done),
        .status     (status),
        .handle_out (handle_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(status, handle_out);
    end

    task automatic send_request(input logic [OP_BITS-1:0] op,
                                input logic [KEY_PORT_BITS-1:0] key,
                                input logic [GEN_BITS-1:0] gen,
                                input logic [HANDLE_PORT_BITS-1:0] handle);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        opcode    <= op;
        conn_key  <= key;
        gen_value <= gen;
        handle_in <= handle;
        do
            @(posedge clk);
        while (busy);
        board.note_request(op, key, gen, handle);
    endtask

    task automatic send_random_item();
        logic [OP_BITS-1:0]          op;
        logic [KEY_PORT_BITS-1:0]    key;
        logic [GEN_BITS-1:0]         gen;
        logic [GEN_BITS-1:0]         known_gen;
        logic [HANDLE_PORT_BITS-1:0] handle;
        int                          pick;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            op = OP_ADD;
        else if (pick < 62)
            op = OP_DROP;
        else if (pick < 95)
            op = OP_FIND;
        else
            op = OP_NONE;
        if ($urandom_range(0, 9) == 0)
            key = $urandom;
        else
            key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        gen = {$urandom, $urandom};
        if (board.stored_gen(key, known_gen) && $urandom_range(0, 99) < 60)
            gen = known_gen;
        if ($urandom_range(0, 19) == 0)
            handle = '0;
        else
            handle = HANDLE_PORT_BITS'($urandom);
        send_request(op, key, gen, handle);
    endtask

    initial
    begin
        int drain;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        opcode    <= OP_ADD;
        conn_key  <= '0;
        gen_value <= '0;
        handle_in <= '0;
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 22;
        send_request(OP_FIND, '0, '0, '0);
        send_request(OP_DROP, '1, GEN_ALL_ONES, '1);
        send_request(OP_ADD, '0, '0, '1);
        send_request(OP_ADD, '1, GEN_ALL_ONES, 16'h0001);
        for (int i = 0; i < SLOTS - 2; i++)
            send_request(OP_ADD, 32'h0000_1000 + i, {$urandom, $urandom},
                         HANDLE_PORT_BITS'($urandom) | 16'h0001);
        // The table is now full, so a new key must be refused.
        send_request(OP_ADD, 32'h5555_AAAA, '0, 16'h00FF);
        send_request(OP_FIND, '1, GEN_ALL_ONES, '0);
        send_request(OP_FIND, '0, 64'h1, '0);
        send_request(OP_ADD, '0, 64'h5, '0);
        send_request(OP_ADD, '0, 64'h5, 16'h1234);
        send_request(OP_NONE, '1, GEN_ALL_ONES, '1);
        send_request(OP_DROP, '0, '0, '0);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 22 : (phase == 1) ? 50 : 0;
            repeat (350) send_random_item();
        end
        start <= 1'b0;

        drain = 0;
        while (board.pending_replies.size() > 0 && drain < 1000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (40) @(posedge clk);
        if (board.error_count == 0 && board.pending_replies.size() == 0)
            $display("status: pass");
        else
        begin
            if (board.pending_replies.size() > 0)
                $display("%0t: %0d expected results never arrived",
                         $time, board.pending_replies.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
